// ===== sv/hee_pkg.sv =====
// Package for the HTML entity escaper: entity table, types and helpers.
`timescale 1ns / 1ps
package hee_pkg;

    localparam int UnitW   = 16;
    localparam int NameLen = 8;
    localparam int CntW    = 4;

    // Name characters, right-justified: last character in byte 0
    typedef logic [NameLen-1:0][7:0] name_t;

    typedef struct packed {
        logic              plain;
        logic [CntW-1:0]   len;
        name_t             name;
        logic [UnitW-1:0]  code;
        logic              text_end;
    } run_t;

    localparam logic [7:0] ChAmp  = 8'h26;
    localparam logic [7:0] ChSemi = 8'h3B;

    // One upper-case hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10)
            r = 8'h30 + {4'h0, n};
        else
            r = 8'h37 + {4'h0, n};
        return r;
    endfunction

    // Count the characters of a right-justified name
    function automatic logic [CntW-1:0] name_len(input name_t nm);
        logic [CntW-1:0] c;
        c = '0;
        for (int i = 0; i < NameLen; i++)
        begin
            if (nm[i] != 8'h00)
                c = c + 1'b1;
        end
        return c;
    endfunction

    // Named entity for a code unit, zero when there is none
    function automatic name_t ent_name(input logic [UnitW-1:0] u);
        logic [63:0] n;
        n = '0;
        case (u)
            16'd34: n = "quot"; 16'd38: n = "amp"; 16'd39: n = "apos";
            16'd60: n = "lt"; 16'd62: n = "gt"; 16'd160: n = "nbsp";
            16'd161: n = "iexcl"; 16'd162: n = "cent"; 16'd163: n = "pound";
            16'd164: n = "curren"; 16'd165: n = "yen"; 16'd166: n = "brvbar";
            16'd167: n = "sect"; 16'd168: n = "uml"; 16'd169: n = "copy";
            16'd170: n = "ordf"; 16'd171: n = "laquo"; 16'd172: n = "not";
            16'd173: n = "shy"; 16'd174: n = "reg"; 16'd175: n = "macr";
            16'd176: n = "deg"; 16'd177: n = "plusmn"; 16'd178: n = "sup2";
            16'd179: n = "sup3"; 16'd180: n = "acute"; 16'd181: n = "micro";
            16'd182: n = "para"; 16'd183: n = "middot"; 16'd184: n = "cedil";
            16'd185: n = "sup1"; 16'd186: n = "ordm"; 16'd187: n = "raquo";
            16'd188: n = "frac14"; 16'd189: n = "frac12"; 16'd190: n = "frac34";
            16'd191: n = "iquest"; 16'd192: n = "Agrave"; 16'd193: n = "Aacute";
            16'd194: n = "Acirc"; 16'd195: n = "Atilde"; 16'd196: n = "Auml";
            16'd197: n = "Aring"; 16'd198: n = "AElig"; 16'd199: n = "Ccedil";
            16'd200: n = "Egrave"; 16'd201: n = "Eacute"; 16'd202: n = "Ecirc";
            16'd203: n = "Euml"; 16'd204: n = "Igrave"; 16'd205: n = "Iacute";
            16'd206: n = "Icirc"; 16'd207: n = "Iuml"; 16'd208: n = "ETH";
            16'd209: n = "Ntilde"; 16'd210: n = "Ograve"; 16'd211: n = "Oacute";
            16'd212: n = "Ocirc"; 16'd213: n = "Otilde"; 16'd214: n = "Ouml";
            16'd215: n = "times"; 16'd216: n = "Oslash"; 16'd217: n = "Ugrave";
            16'd218: n = "Uacute"; 16'd219: n = "Ucirc"; 16'd220: n = "Uuml";
            16'd221: n = "Yacute"; 16'd222: n = "THORN"; 16'd223: n = "szlig";
            16'd224: n = "agrave"; 16'd225: n = "aacute"; 16'd226: n = "acirc";
            16'd227: n = "atilde"; 16'd228: n = "auml"; 16'd229: n = "aring";
            16'd230: n = "aelig"; 16'd231: n = "ccedil"; 16'd232: n = "egrave";
            16'd233: n = "eacute"; 16'd234: n = "ecirc"; 16'd235: n = "euml";
            16'd236: n = "igrave"; 16'd237: n = "iacute"; 16'd238: n = "icirc";
            16'd239: n = "iuml"; 16'd240: n = "eth"; 16'd241: n = "ntilde";
            16'd242: n = "ograve"; 16'd243: n = "oacute"; 16'd244: n = "ocirc";
            16'd245: n = "otilde"; 16'd246: n = "ouml"; 16'd247: n = "divide";
            16'd248: n = "oslash"; 16'd249: n = "ugrave"; 16'd250: n = "uacute";
            16'd251: n = "ucirc"; 16'd252: n = "uuml"; 16'd253: n = "yacute";
            16'd254: n = "thorn"; 16'd255: n = "yuml"; 16'd338: n = "OElig";
            16'd339: n = "oelig"; 16'd352: n = "Scaron"; 16'd353: n = "scaron";
            16'd376: n = "Yuml"; 16'd402: n = "fnof"; 16'd710: n = "circ";
            16'd732: n = "tilde"; 16'd913: n = "Alpha"; 16'd914: n = "Beta";
            16'd915: n = "Gamma"; 16'd916: n = "Delta"; 16'd917: n = "Epsilon";
            16'd918: n = "Zeta"; 16'd919: n = "Eta"; 16'd920: n = "Theta";
            16'd921: n = "Iota"; 16'd922: n = "Kappa"; 16'd923: n = "Lambda";
            16'd924: n = "Mu"; 16'd925: n = "Nu"; 16'd926: n = "Xi";
            16'd927: n = "Omicron"; 16'd928: n = "Pi"; 16'd929: n = "Rho";
            16'd931: n = "Sigma"; 16'd932: n = "Tau"; 16'd933: n = "Upsilon";
            16'd934: n = "Phi"; 16'd935: n = "Chi"; 16'd936: n = "Psi";
            16'd937: n = "Omega"; 16'd945: n = "alpha"; 16'd946: n = "beta";
            16'd947: n = "gamma"; 16'd948: n = "delta"; 16'd949: n = "epsilon";
            16'd950: n = "zeta"; 16'd951: n = "eta"; 16'd952: n = "theta";
            16'd953: n = "iota"; 16'd954: n = "kappa"; 16'd955: n = "lambda";
            16'd956: n = "mu"; 16'd957: n = "nu"; 16'd958: n = "xi";
            16'd959: n = "omicron"; 16'd960: n = "pi"; 16'd961: n = "rho";
            16'd962: n = "sigmaf"; 16'd963: n = "sigma"; 16'd964: n = "tau";
            16'd965: n = "upsilon"; 16'd966: n = "phi"; 16'd967: n = "chi";
            16'd968: n = "psi"; 16'd969: n = "omega"; 16'd977: n = "thetasym";
            16'd978: n = "upsih"; 16'd982: n = "piv"; 16'd8194: n = "ensp";
            16'd8195: n = "emsp"; 16'd8201: n = "thinsp"; 16'd8204: n = "zwnj";
            16'd8205: n = "zwj"; 16'd8206: n = "lrm"; 16'd8207: n = "rlm";
            16'd8211: n = "ndash"; 16'd8212: n = "mdash"; 16'd8216: n = "lsquo";
            16'd8217: n = "rsquo"; 16'd8218: n = "sbquo"; 16'd8220: n = "ldquo";
            16'd8221: n = "rdquo"; 16'd8222: n = "bdquo"; 16'd8224: n = "dagger";
            16'd8225: n = "Dagger"; 16'd8226: n = "bull"; 16'd8230: n = "hellip";
            16'd8240: n = "permil"; 16'd8242: n = "prime"; 16'd8243: n = "Prime";
            16'd8249: n = "lsaquo"; 16'd8250: n = "rsaquo"; 16'd8254: n = "oline";
            16'd8260: n = "frasl"; 16'd8364: n = "euro"; 16'd8465: n = "image";
            16'd8472: n = "weierp"; 16'd8476: n = "real"; 16'd8482: n = "trade";
            16'd8501: n = "alefsym"; 16'd8592: n = "larr"; 16'd8593: n = "uarr";
            16'd8594: n = "rarr"; 16'd8595: n = "darr"; 16'd8596: n = "harr";
            16'd8629: n = "crarr"; 16'd8656: n = "lArr"; 16'd8657: n = "uArr";
            16'd8658: n = "rArr"; 16'd8659: n = "dArr"; 16'd8660: n = "hArr";
            16'd8704: n = "forall"; 16'd8706: n = "part"; 16'd8707: n = "exist";
            16'd8709: n = "empty"; 16'd8711: n = "nabla"; 16'd8712: n = "isin";
            16'd8713: n = "notin"; 16'd8715: n = "ni"; 16'd8719: n = "prod";
            16'd8721: n = "sum"; 16'd8722: n = "minus"; 16'd8727: n = "lowast";
            16'd8730: n = "radic"; 16'd8733: n = "prop"; 16'd8734: n = "infin";
            16'd8736: n = "ang"; 16'd8743: n = "and"; 16'd8744: n = "or";
            16'd8745: n = "cap"; 16'd8746: n = "cup"; 16'd8747: n = "int";
            16'd8756: n = "there4"; 16'd8764: n = "sim"; 16'd8773: n = "cong";
            16'd8776: n = "asymp"; 16'd8800: n = "ne"; 16'd8801: n = "equiv";
            16'd8804: n = "le"; 16'd8805: n = "ge"; 16'd8834: n = "sub";
            16'd8835: n = "sup"; 16'd8836: n = "nsub"; 16'd8838: n = "sube";
            16'd8839: n = "supe"; 16'd8853: n = "oplus"; 16'd8855: n = "otimes";
            16'd8869: n = "perp"; 16'd8901: n = "sdot"; 16'd8968: n = "lceil";
            16'd8969: n = "rceil"; 16'd8970: n = "lfloor"; 16'd8971: n = "rfloor";
            16'd9001: n = "lang"; 16'd9002: n = "rang"; 16'd9674: n = "loz";
            16'd9824: n = "spades"; 16'd9827: n = "clubs"; 16'd9829: n = "hearts";
            16'd9830: n = "diams";
            default: n = '0;
        endcase
        return name_t'(n);
    endfunction

endpackage

// ===== sv/html_entity_escaper.sv =====
// Top level of the HTML entity escaper: register, lookup and expansion stages.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------
//  input   | in_valid  | in_stall  | code_unit, text_end
//  output  | out_valid | out_stall | out_unit, run_last, text_done
//
// A plain unit takes one cycle per request and an escaped unit one cycle
// per emitted unit (6 for control units, name length + 2 for entities),
// while the output does not stall; this is set by the single expansion
// register that walks the run. Four register stages: input register,
// table lookup, expansion, output register; each request passes them in order.
// Reset clears all valid bits. A stall on the output
// backs up the stages and raises in_stall; nothing is lost or repeated.
`timescale 1ns / 1ps
module html_entity_escaper
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] code_unit,
    input  logic        text_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] out_unit,
    output logic        run_last,
    output logic        text_done
);

    logic                    a_valid_reg;
    logic [15:0]             a_code_reg;
    logic                    a_end_reg;
    logic                    b_valid_reg;
    hee_pkg::run_t           b_run_reg;
    hee_pkg::run_t           b_run_next;
    logic                    c_valid_reg;
    hee_pkg::run_t           c_run_reg;
    logic [hee_pkg::CntW-1:0] c_idx_reg;
    logic [hee_pkg::CntW-1:0] c_cnt;
    logic [2:0]              c_byte;
    logic [15:0]             c_unit;
    logic                    out_valid_reg;
    logic [15:0]             out_unit_reg;
    logic                    run_last_reg;
    logic                    text_done_reg;
    logic                    out_take;
    logic                    emit;
    logic                    c_done;
    logic                    c_load;
    logic                    b_adv;
    logic                    a_adv;
    hee_pkg::name_t          ent;

    // Handshake chain from the output back to the input
    assign out_take = !out_valid_reg || !out_stall;
    assign c_cnt    = c_run_reg.plain ? 4'd1 : c_run_reg.len + 4'd2;
    assign emit     = c_valid_reg && out_take;
    assign c_done   = emit && (c_idx_reg == c_cnt - 4'd1);
    assign c_load   = !c_valid_reg || c_done;
    assign b_adv    = !b_valid_reg || c_load;
    assign a_adv    = !a_valid_reg || b_adv;
    assign in_stall = !a_adv;

    // Classify the unit and fetch its escape name
    always_comb
    begin
        ent = hee_pkg::ent_name(a_code_reg);
        b_run_next.code     = a_code_reg;
        b_run_next.text_end = a_end_reg;
        if (a_code_reg[15:5] == '0)
        begin
            b_run_next.plain = 1'b0;
            b_run_next.name  = '0;
            b_run_next.name[3] = 8'h23;
            b_run_next.name[2] = 8'h78;
            b_run_next.name[1] = hee_pkg::hex_char({3'b000, a_code_reg[4]});
            b_run_next.name[0] = hee_pkg::hex_char(a_code_reg[3:0]);
            b_run_next.len   = 4'd4;
        end
        else
        begin
            b_run_next.plain = (ent == '0);
            b_run_next.name  = ent;
            b_run_next.len   = hee_pkg::name_len(ent);
        end
    end

    // Select the unit at the current run position
    always_comb
    begin
        c_byte = c_run_reg.len[2:0] - c_idx_reg[2:0];
        if (c_run_reg.plain)
            c_unit = c_run_reg.code;
        else if (c_idx_reg == '0)
            c_unit = {8'h00, hee_pkg::ChAmp};
        else if (c_idx_reg == c_run_reg.len + 4'd1)
            c_unit = {8'h00, hee_pkg::ChSemi};
        else
            c_unit = {8'h00, c_run_reg.name[c_byte]};
    end

    // Advance valid bits through the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            c_idx_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_adv)
                a_valid_reg <= in_valid;
            if (b_adv)
                b_valid_reg <= a_valid_reg;
            if (c_load)
            begin
                c_valid_reg <= b_valid_reg;
                c_idx_reg   <= '0;
            end
            else if (emit)
                c_idx_reg <= c_idx_reg + 4'd1;
            if (out_take)
                out_valid_reg <= emit;
        end
    end

    // Hold payloads while their stage waits
    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            a_code_reg <= code_unit;
            a_end_reg  <= text_end;
        end
        if (b_adv)
            b_run_reg <= b_run_next;
        if (c_load)
            c_run_reg <= b_run_reg;
        if (out_take)
        begin
            out_unit_reg  <= c_unit;
            run_last_reg  <= c_done;
            text_done_reg <= c_done && c_run_reg.text_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_unit  = out_unit_reg;
    assign run_last  = run_last_reg;
    assign text_done = text_done_reg;

endmodule

// ===== bench/escape_checker.sv =====
// Checker for the HTML entity escaper: predicts escaped runs and compares results.
`timescale 1ns / 1ps
module escape_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [15:0] code_unit,
    input  logic        text_end,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] out_unit,
    input  logic        run_last,
    input  logic        text_done,
    output int          fail_count,
    output int          pending_units
);

    typedef struct packed {
        logic [15:0] unit;
        logic        last;
        logic        done;
    } esc_unit_t;

    esc_unit_t expected_units[$];

    // Entity name of a code unit as a string; empty when none
    function automatic string entity_name(input logic [15:0] u);
        string s;
        case (u)
            34: s = "quot"; 38: s = "amp"; 39: s = "apos"; 60: s = "lt"; 62: s = "gt";
            160: s = "nbsp"; 161: s = "iexcl"; 162: s = "cent"; 163: s = "pound";
            164: s = "curren"; 165: s = "yen"; 166: s = "brvbar"; 167: s = "sect";
            168: s = "uml"; 169: s = "copy"; 170: s = "ordf"; 171: s = "laquo";
            172: s = "not"; 173: s = "shy"; 174: s = "reg"; 175: s = "macr";
            176: s = "deg"; 177: s = "plusmn"; 178: s = "sup2"; 179: s = "sup3";
            180: s = "acute"; 181: s = "micro"; 182: s = "para"; 183: s = "middot";
            184: s = "cedil"; 185: s = "sup1"; 186: s = "ordm"; 187: s = "raquo";
            188: s = "frac14"; 189: s = "frac12"; 190: s = "frac34"; 191: s = "iquest";
            192: s = "Agrave"; 193: s = "Aacute"; 194: s = "Acirc"; 195: s = "Atilde";
            196: s = "Auml"; 197: s = "Aring"; 198: s = "AElig"; 199: s = "Ccedil";
            200: s = "Egrave"; 201: s = "Eacute"; 202: s = "Ecirc"; 203: s = "Euml";
            204: s = "Igrave"; 205: s = "Iacute"; 206: s = "Icirc"; 207: s = "Iuml";
            208: s = "ETH"; 209: s = "Ntilde"; 210: s = "Ograve"; 211: s = "Oacute";
            212: s = "Ocirc"; 213: s = "Otilde"; 214: s = "Ouml"; 215: s = "times";
            216: s = "Oslash"; 217: s = "Ugrave"; 218: s = "Uacute"; 219: s = "Ucirc";
            220: s = "Uuml"; 221: s = "Yacute"; 222: s = "THORN"; 223: s = "szlig";
            224: s = "agrave"; 225: s = "aacute"; 226: s = "acirc"; 227: s = "atilde";
            228: s = "auml"; 229: s = "aring"; 230: s = "aelig"; 231: s = "ccedil";
            232: s = "egrave"; 233: s = "eacute"; 234: s = "ecirc"; 235: s = "euml";
            236: s = "igrave"; 237: s = "iacute"; 238: s = "icirc"; 239: s = "iuml";
            240: s = "eth"; 241: s = "ntilde"; 242: s = "ograve"; 243: s = "oacute";
            244: s = "ocirc"; 245: s = "otilde"; 246: s = "ouml"; 247: s = "divide";
            248: s = "oslash"; 249: s = "ugrave"; 250: s = "uacute"; 251: s = "ucirc";
            252: s = "uuml"; 253: s = "yacute"; 254: s = "thorn"; 255: s = "yuml";
            338: s = "OElig"; 339: s = "oelig"; 352: s = "Scaron"; 353: s = "scaron";
            376: s = "Yuml"; 402: s = "fnof"; 710: s = "circ"; 732: s = "tilde";
            913: s = "Alpha"; 914: s = "Beta"; 915: s = "Gamma"; 916: s = "Delta";
            917: s = "Epsilon"; 918: s = "Zeta"; 919: s = "Eta"; 920: s = "Theta";
            921: s = "Iota"; 922: s = "Kappa"; 923: s = "Lambda"; 924: s = "Mu";
            925: s = "Nu"; 926: s = "Xi"; 927: s = "Omicron"; 928: s = "Pi";
            929: s = "Rho"; 931: s = "Sigma"; 932: s = "Tau"; 933: s = "Upsilon";
            934: s = "Phi"; 935: s = "Chi"; 936: s = "Psi"; 937: s = "Omega";
            945: s = "alpha"; 946: s = "beta"; 947: s = "gamma"; 948: s = "delta";
            949: s = "epsilon"; 950: s = "zeta"; 951: s = "eta"; 952: s = "theta";
            953: s = "iota"; 954: s = "kappa"; 955: s = "lambda"; 956: s = "mu";
            957: s = "nu"; 958: s = "xi"; 959: s = "omicron"; 960: s = "pi";
            961: s = "rho"; 962: s = "sigmaf"; 963: s = "sigma"; 964: s = "tau";
            965: s = "upsilon"; 966: s = "phi"; 967: s = "chi"; 968: s = "psi";
            969: s = "omega"; 977: s = "thetasym"; 978: s = "upsih"; 982: s = "piv";
            8194: s = "ensp"; 8195: s = "emsp"; 8201: s = "thinsp"; 8204: s = "zwnj";
            8205: s = "zwj"; 8206: s = "lrm"; 8207: s = "rlm"; 8211: s = "ndash";
            8212: s = "mdash"; 8216: s = "lsquo"; 8217: s = "rsquo"; 8218: s = "sbquo";
            8220: s = "ldquo"; 8221: s = "rdquo"; 8222: s = "bdquo"; 8224: s = "dagger";
            8225: s = "Dagger"; 8226: s = "bull"; 8230: s = "hellip"; 8240: s = "permil";
            8242: s = "prime"; 8243: s = "Prime"; 8249: s = "lsaquo"; 8250: s = "rsaquo";
            8254: s = "oline"; 8260: s = "frasl"; 8364: s = "euro"; 8465: s = "image";
            8472: s = "weierp"; 8476: s = "real"; 8482: s = "trade"; 8501: s = "alefsym";
            8592: s = "larr"; 8593: s = "uarr"; 8594: s = "rarr"; 8595: s = "darr";
            8596: s = "harr"; 8629: s = "crarr"; 8656: s = "lArr"; 8657: s = "uArr";
            8658: s = "rArr"; 8659: s = "dArr"; 8660: s = "hArr"; 8704: s = "forall";
            8706: s = "part"; 8707: s = "exist"; 8709: s = "empty"; 8711: s = "nabla";
            8712: s = "isin"; 8713: s = "notin"; 8715: s = "ni"; 8719: s = "prod";
            8721: s = "sum"; 8722: s = "minus"; 8727: s = "lowast"; 8730: s = "radic";
            8733: s = "prop"; 8734: s = "infin"; 8736: s = "ang"; 8743: s = "and";
            8744: s = "or"; 8745: s = "cap"; 8746: s = "cup"; 8747: s = "int";
            8756: s = "there4"; 8764: s = "sim"; 8773: s = "cong"; 8776: s = "asymp";
            8800: s = "ne"; 8801: s = "equiv"; 8804: s = "le"; 8805: s = "ge";
            8834: s = "sub"; 8835: s = "sup"; 8836: s = "nsub"; 8838: s = "sube";
            8839: s = "supe"; 8853: s = "oplus"; 8855: s = "otimes"; 8869: s = "perp";
            8901: s = "sdot"; 8968: s = "lceil"; 8969: s = "rceil"; 8970: s = "lfloor";
            8971: s = "rfloor"; 9001: s = "lang"; 9002: s = "rang"; 9674: s = "loz";
            9824: s = "spades"; 9827: s = "clubs"; 9829: s = "hearts"; 9830: s = "diams";
            default: s = "";
        endcase
        return s;
    endfunction

    function automatic logic [15:0] hex_digit(input logic [3:0] n);
        return (n < 10) ? 16'h30 + n : 16'h37 + n;
    endfunction

    // Build the escaped run of one request
    task automatic push_escaped_run(input logic [15:0] u, input logic fin);
        logic [15:0] run[$];
        string nm;
        run = {};
        nm = entity_name(u);
        if (u < 16'd32)
            run = {16'h26, 16'h23, 16'h78, hex_digit(u[7:4]), hex_digit(u[3:0]), 16'h3B};
        else if (nm.len() > 0)
        begin
            run.push_back(16'h26);
            for (int i = 0; i < nm.len(); i++)
                run.push_back({8'h00, nm[i]});
            run.push_back(16'h3B);
        end
        else
            run.push_back(u);
        for (int k = 0; k < run.size(); k++)
            expected_units.push_back('{run[k], k == run.size() - 1,
                                       (k == run.size() - 1) && fin});
    endtask

    assign pending_units = expected_units.size();

    // Predict on accepted requests, compare on accepted results
    always @(posedge clk or negedge rst_n)
    begin
        esc_unit_t e;
        if (!rst_n)
        begin
            fail_count <= 0;
            expected_units.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_units.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result unit=%h last=%b done=%b",
                                 out_unit, run_last, text_done);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_units.pop_front();
                    if (e.unit !== out_unit || e.last !== run_last || e.done !== text_done)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected unit=%h last=%b done=%b, got %h %b %b",
                                     e.unit, e.last, e.done, out_unit, run_last, text_done);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                push_escaped_run(code_unit, text_end);
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the HTML entity escaper: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_top;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] code_unit;
    logic        text_end;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] out_unit;
    logic        run_last;
    logic        text_done;
    int          fail_count;
    int          pending_units;
    int          cycle_count = 0;
    bit          stall_on = 1'b0;

    localparam int CycleLimit = 200000;

    html_entity_escaper uut
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .code_unit(code_unit), .text_end(text_end), .out_valid(out_valid),
        .out_stall(out_stall), .out_unit(out_unit), .run_last(run_last),
        .text_done(text_done)
    );

    escape_checker chk
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .code_unit(code_unit), .text_end(text_end), .out_valid(out_valid),
        .out_stall(out_stall), .out_unit(out_unit), .run_last(run_last),
        .text_done(text_done), .fail_count(fail_count), .pending_units(pending_units)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Stall the output in alternating random stretches, some of them quiet
    always @(negedge clk)
    begin
        if ($urandom_range(0, 15) == 0)
            stall_on <= !stall_on;
        out_stall <= stall_on ? ($urandom_range(0, 2) != 0) : 1'b0;
    end

    // Present one request, hold it until accepted
    task automatic send_unit(input logic [15:0] u, input logic fin);
        code_unit <= u;
        text_end  <= fin;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Random gap between bursts
    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 4);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            code_unit <= 16'($urandom);
            repeat (n) @(negedge clk);
        end
    endtask

    function automatic logic [15:0] pick_unit();
        int sel;
        logic [15:0] ent_codes[12];
        ent_codes = '{34, 38, 39, 60, 62, 160, 255, 977, 8501, 9830, 8364, 402};
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1: return 16'($urandom_range(0, 31));
            2, 3: return ent_codes[$urandom_range(0, 11)];
            4: return 16'($urandom_range(160, 255));
            5: return 16'($urandom_range(913, 982));
            6: return 16'($urandom_range(8192, 9830));
            7: return 16'($urandom_range(16'hD800, 16'hDFFF));
            8: return 16'($urandom_range(32, 127));
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [15:0] directed[$];
        int burst;
        int left;
        rst_n = 1'b0;
        in_valid = 1'b0;
        code_unit = '0;
        text_end = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Extremes, controls incl. tab/LF/CR, entity ends, longest name, surrogates
        directed = {16'h0000, 16'h001F, 16'h0009, 16'h000A, 16'h000D, 16'h0020,
                    16'd34, 16'd9830, 16'd977, 16'd8501, 16'd38, 16'd60,
                    16'hD800, 16'hDFFF, 16'hFFFF, 16'h7FFF, 16'h0041, 16'd161,
                    16'd8800, 16'd930, 16'hAAAA, 16'h5555};
        foreach (directed[i])
            send_unit(directed[i], (i % 5) == 4);
        idle_gap();

        left = 150;
        while (left > 0)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && left > 0)
            begin
                send_unit(pick_unit(), $urandom_range(0, 7) == 0);
                burst--;
                left--;
            end
            idle_gap();
        end
        in_valid <= 1'b0;

        while (pending_units != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending_units == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
